// ===== rtl/rgbds_pkg.sv =====
// Shared constants, types and helpers for the RGB888 downscaler.
`default_nettype none

package rgbds_pkg;

    // Output image size defaults
    localparam int OUT_WIDTH_DEF  = 320;
    localparam int OUT_HEIGHT_DEF = 180;

    // Source geometry
    localparam int SIZE_W   = 13;
    localparam int COUNT_W  = 12;
    localparam int MAX_SIZE = 4096;

    // Pixel data
    localparam int BYTE_W   = 8;
    localparam int GAIN_W   = 8;
    localparam int PIXEL_W  = 16;
    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Divide by 100 as multiply by reciprocal, exact for any 16-bit product
    localparam int              PROD_W       = 16;
    localparam int              DIV100_MUL_W = 17;
    localparam logic [16:0]     DIV100_MUL   = 17'd83887;
    localparam int              DIV100_SHIFT = 23;
    localparam int              WIDE_W       = PROD_W + DIV100_MUL_W;
    localparam int              QUOT_W       = 10;
    localparam int              SUM_W        = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register reset values
    localparam logic [SIZE_W-1:0]        SRC_WIDTH_RST    = 13'd1280;
    localparam logic [SIZE_W-1:0]        SRC_HEIGHT_RST   = 13'd720;
    localparam logic [GAIN_W-1:0]        RED_GAIN_RST     = 8'd135;
    localparam logic [GAIN_W-1:0]        GREEN_GAIN_RST   = 8'd98;
    localparam logic [GAIN_W-1:0]        BLUE_GAIN_RST    = 8'd88;
    localparam logic signed [BYTE_W-1:0] RED_OFFSET_RST   = 8'sd14;
    localparam logic signed [BYTE_W-1:0] GREEN_OFFSET_RST = 8'sd12;
    localparam logic signed [BYTE_W-1:0] BLUE_OFFSET_RST  = 8'sd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH    = 3'd0,
        CFG_SRC_HEIGHT   = 3'd1,
        CFG_RED_GAIN     = 3'd2,
        CFG_GREEN_GAIN   = 3'd3,
        CFG_BLUE_GAIN    = 3'd4,
        CFG_RED_OFFSET   = 3'd5,
        CFG_GREEN_OFFSET = 3'd6,
        CFG_BLUE_OFFSET  = 3'd7
    } cfg_idx_t;

    // Colour correction settings handed to the back end
    typedef struct packed {
        logic [GAIN_W-1:0]        red_gain;
        logic [GAIN_W-1:0]        green_gain;
        logic [GAIN_W-1:0]        blue_gain;
        logic signed [BYTE_W-1:0] red_offset;
        logic signed [BYTE_W-1:0] green_offset;
        logic signed [BYTE_W-1:0] blue_offset;
    } tone_cfg_t;

    // Read a zero size as 1 and anything beyond the maximum as the maximum
    function automatic logic [SIZE_W-1:0] clip_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_W'(MAX_SIZE))
            r = SIZE_W'(MAX_SIZE);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbds_queue.sv =====
// Small flop-based queue decoupling the pixel selector from the colour pipeline.
`default_nettype none

module rgbds_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rgbds_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry on push
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/rgbds_front.sv =====
// Front end: tracks source position and picks the nearest-neighbour pixels.
`default_nettype none

module rgbds_front #(
    parameter int OUT_WIDTH  = rgbds_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = rgbds_pkg::OUT_HEIGHT_DEF,
    localparam int COL_W = $clog2(OUT_WIDTH),
    localparam int ROW_W = $clog2(OUT_HEIGHT)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          start_of_frame,
    input  wire logic [rgbds_pkg::SIZE_W-1:0]  src_width,
    input  wire logic [rgbds_pkg::SIZE_W-1:0]  src_height,
    input  wire logic                          queue_full,
    output logic                               push,
    output logic [COL_W-1:0]                   col,
    output logic [ROW_W-1:0]                   row,
    output logic                               frame_end
);

    localparam int SW  = rgbds_pkg::SIZE_W;
    localparam int CW  = rgbds_pkg::COUNT_W;
    localparam int OCW = $clog2(OUT_WIDTH + 1);
    localparam int ORW = $clog2(OUT_HEIGHT + 1);
    // Signed error terms: chosen output position times source size,
    // less source position times output size
    localparam int ECW = $clog2(2 * rgbds_pkg::MAX_SIZE + OUT_WIDTH) + 1;
    localparam int ERW = $clog2(2 * rgbds_pkg::MAX_SIZE + OUT_HEIGHT) + 1;
    localparam logic signed [ECW-1:0] OW_E = ECW'(OUT_WIDTH);
    localparam logic signed [ERW-1:0] OH_E = ERW'(OUT_HEIGHT);

    logic [CW-1:0]         col_count_reg, col_count_next;
    logic [CW-1:0]         row_count_reg, row_count_next;
    logic [OCW-1:0]        out_col_reg, out_col_next;
    logic [ORW-1:0]        out_row_reg, out_row_next;
    logic signed [ECW-1:0] col_err_reg, col_err_next;
    logic signed [ERW-1:0] row_err_reg, row_err_next;

    logic [SW-1:0]         w;
    logic [SW-1:0]         h;
    logic [CW-1:0]         cur_col_count;
    logic [CW-1:0]         cur_row_count;
    logic [OCW-1:0]        cur_out_col;
    logic [ORW-1:0]        cur_out_row;
    logic signed [ECW-1:0] cur_col_err;
    logic signed [ERW-1:0] cur_row_err;
    logic signed [ECW-1:0] col_err_sum;
    logic signed [ERW-1:0] row_err_sum;
    logic                  row_live;
    logic                  emit;
    logic                  line_end;
    logic                  frame_over;
    logic                  accept;

    assign w = rgbds_pkg::clip_size(src_width);
    assign h = rgbds_pkg::clip_size(src_height);

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Start of frame clears the state before this pixel is looked at
    assign cur_col_count = start_of_frame ? '0 : col_count_reg;
    assign cur_row_count = start_of_frame ? '0 : row_count_reg;
    assign cur_out_col   = start_of_frame ? '0 : out_col_reg;
    assign cur_out_row   = start_of_frame ? '0 : out_row_reg;
    assign cur_col_err   = start_of_frame ? '0 : col_err_reg;
    assign cur_row_err   = start_of_frame ? '0 : row_err_reg;

    // Classify: a pixel is kept when its row and column are both the chosen ones
    assign row_live = (cur_out_row < ORW'(OUT_HEIGHT)) && !cur_row_err[ERW-1]
                      && (cur_row_err < OH_E);
    assign emit     = row_live && (cur_out_col < OCW'(OUT_WIDTH)) && !cur_col_err[ECW-1]
                      && (cur_col_err < OW_E);

    assign line_end   = ({1'b0, cur_col_count} + SW'(1)) >= w;
    assign frame_over = line_end && (({1'b0, cur_row_count} + SW'(1)) >= h);

    // Step the error terms; once negative the target has passed for good
    assign col_err_sum = cur_col_err + (emit ? $signed(ECW'(w)) : '0) - OW_E;
    assign row_err_sum = cur_row_err + (row_live ? $signed(ERW'(h)) : '0) - OH_E;

    // Next source position and selection state
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        col_err_next   = col_err_reg;
        row_err_next   = row_err_reg;
        if (accept)
        begin
            if (frame_over)
            begin
                col_count_next = '0;
                row_count_next = '0;
                out_col_next   = '0;
                out_row_next   = '0;
                col_err_next   = '0;
                row_err_next   = '0;
            end
            else if (line_end)
            begin
                col_count_next = '0;
                out_col_next   = '0;
                col_err_next   = '0;
                row_count_next = cur_row_count + 1'b1;
                out_row_next   = cur_out_row + ORW'(row_live);
                row_err_next   = row_err_sum[ERW-1] ? '1 : row_err_sum;
            end
            else
            begin
                col_count_next = cur_col_count + 1'b1;
                row_count_next = cur_row_count;
                out_col_next   = cur_out_col + OCW'(emit);
                out_row_next   = cur_out_row;
                col_err_next   = col_err_sum[ECW-1] ? '1 : col_err_sum;
                row_err_next   = cur_row_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            col_err_reg   <= '0;
            row_err_reg   <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            col_err_reg   <= col_err_next;
            row_err_reg   <= row_err_next;
        end
    end

    // Hand the kept pixel's position to the queue
    assign push      = accept && emit;
    assign col       = cur_out_col[COL_W-1:0];
    assign row       = cur_out_row[ROW_W-1:0];
    assign frame_end = (cur_out_col == OCW'(OUT_WIDTH - 1))
                       && (cur_out_row == ORW'(OUT_HEIGHT - 1));

endmodule

`default_nettype wire

// ===== rtl/rgbds_back.sv =====
// Back end: per-channel gain, offset and clamp, RGB565 packing, output register.
`default_nettype none

module rgbds_back #(
    parameter int COL_W = 9,
    parameter int ROW_W = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rgbds_pkg::tone_cfg_t           tone_cfg,
    input  wire logic                           queue_empty,
    output logic                                pop,
    input  wire logic [rgbds_pkg::BYTE_W-1:0]   red_in,
    input  wire logic [rgbds_pkg::BYTE_W-1:0]   green_in,
    input  wire logic [rgbds_pkg::BYTE_W-1:0]   blue_in,
    input  wire logic [COL_W-1:0]               col_in,
    input  wire logic [ROW_W-1:0]               row_in,
    input  wire logic                           frame_end_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rgbds_pkg::PIXEL_W-1:0]       pixel565,
    output logic [COL_W-1:0]                    out_col,
    output logic [ROW_W-1:0]                    out_row,
    output logic                                frame_end
);

    localparam int BW = rgbds_pkg::BYTE_W;
    localparam int PW = rgbds_pkg::PROD_W;
    localparam int MW = rgbds_pkg::DIV100_MUL_W;
    localparam int XW = rgbds_pkg::WIDE_W;
    localparam int QW = rgbds_pkg::QUOT_W;
    localparam int TW = rgbds_pkg::SUM_W;
    localparam int NC = rgbds_pkg::NUM_CH;
    localparam int SH = rgbds_pkg::DIV100_SHIFT;

    logic                     advance;
    logic [NC-1:0][BW-1:0]    chan_in;
    logic [NC-1:0][BW-1:0]    gain;
    logic [NC-1:0][BW-1:0]    offset;

    // Stage 1: products
    logic                     s1_valid_reg, s1_valid_next;
    logic [NC-1:0][PW-1:0]    s1_prod_reg, s1_prod_next;
    logic [COL_W-1:0]         s1_col_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic                     s1_fe_reg;

    // Stage 2: quotients by 100
    logic                     s2_valid_reg, s2_valid_next;
    logic [NC-1:0][QW-1:0]    s2_quot_reg, s2_quot_next;
    logic [NC-1:0][XW-1:0]    wide_prod;
    logic [COL_W-1:0]         s2_col_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic                     s2_fe_reg;

    // Stage 3: offset, clamp, pack into the output register
    logic                     out_valid_reg, out_valid_next;
    logic [NC-1:0][TW-1:0]    tone_sum;
    logic [NC-1:0][BW-1:0]    tone_val;
    logic [rgbds_pkg::PIXEL_W-1:0] pixel_reg, pixel_next;
    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic                     fe_reg;

    // Whole pipeline moves when the output register is free or being drained
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !queue_empty;

    assign chan_in[rgbds_pkg::CH_RED]   = red_in;
    assign chan_in[rgbds_pkg::CH_GREEN] = green_in;
    assign chan_in[rgbds_pkg::CH_BLUE]  = blue_in;
    assign gain[rgbds_pkg::CH_RED]      = tone_cfg.red_gain;
    assign gain[rgbds_pkg::CH_GREEN]    = tone_cfg.green_gain;
    assign gain[rgbds_pkg::CH_BLUE]     = tone_cfg.blue_gain;
    assign offset[rgbds_pkg::CH_RED]    = tone_cfg.red_offset;
    assign offset[rgbds_pkg::CH_GREEN]  = tone_cfg.green_offset;
    assign offset[rgbds_pkg::CH_BLUE]   = tone_cfg.blue_offset;

    // Per-channel arithmetic
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            s1_prod_next[i] = {{(PW-BW){1'b0}}, chan_in[i]} * {{(PW-BW){1'b0}}, gain[i]};
            wide_prod[i]    = {{MW{1'b0}}, s1_prod_reg[i]}
                              * {{PW{1'b0}}, rgbds_pkg::DIV100_MUL};
            s2_quot_next[i] = wide_prod[i][SH +: QW];
            tone_sum[i]     = $signed({{(TW-QW){1'b0}}, s2_quot_reg[i]})
                              + $signed({{(TW-BW){offset[i][BW-1]}}, offset[i]});
            if (tone_sum[i][TW-1])
                tone_val[i] = '0;
            else if (tone_sum[i][TW-2:BW] != '0)
                tone_val[i] = '1;
            else
                tone_val[i] = tone_sum[i][BW-1:0];
        end
    end

    assign pixel_next = {tone_val[rgbds_pkg::CH_RED][7:3],
                         tone_val[rgbds_pkg::CH_GREEN][7:2],
                         tone_val[rgbds_pkg::CH_BLUE][7:3]};

    // Valid flags advance with the pipeline
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            s1_valid_next  = pop;
            s2_valid_next  = s1_valid_reg;
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload stages hold while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_col_reg  <= col_in;
            s1_row_reg  <= row_in;
            s1_fe_reg   <= frame_end_in;
            s2_quot_reg <= s2_quot_next;
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
            s2_fe_reg   <= s1_fe_reg;
            pixel_reg   <= pixel_next;
            col_reg     <= s2_col_reg;
            row_reg     <= s2_row_reg;
            fe_reg      <= s2_fe_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel565  = pixel_reg;
    assign out_col   = col_reg;
    assign out_row   = row_reg;
    assign frame_end = fe_reg;

endmodule

`default_nettype wire

// ===== rtl/rgb888_downscale_gain_to_rgb565.sv =====
// Throughput: one source pixel per cycle while the queue is not full; kept pixels
// leave at one per cycle while out_ready is high.
// The colour path is three registered stages (product, divide by 100, clamp and pack)
// behind a two-entry queue; output stalls back up through the queue to in_ready.
// Reset: asynchronous, active low; clears position counters, queue and valid flags
// and loads the register defaults (1280x720 source, default gains and offsets).
`default_nettype none

module rgb888_downscale_gain_to_rgb565 #(
    parameter int OUT_WIDTH  = rgbds_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = rgbds_pkg::OUT_HEIGHT_DEF,
    localparam int COL_W = $clog2(OUT_WIDTH),
    localparam int ROW_W = $clog2(OUT_HEIGHT)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration
    input  wire logic                              cfg_write,
    input  wire logic [rgbds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rgbds_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Source pixels
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              start_of_frame,
    input  wire logic [rgbds_pkg::BYTE_W-1:0]      first_byte,
    input  wire logic [rgbds_pkg::BYTE_W-1:0]      second_byte,
    input  wire logic [rgbds_pkg::BYTE_W-1:0]      third_byte,
    // Output pixels
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [rgbds_pkg::PIXEL_W-1:0]          pixel565,
    output logic [COL_W-1:0]                       out_col,
    output logic [ROW_W-1:0]                       out_row,
    output logic                                   frame_end
);

    localparam int BW      = rgbds_pkg::BYTE_W;
    localparam int QUEUE_W = 1 + ROW_W + COL_W + 3 * BW;

    logic [rgbds_pkg::SIZE_W-1:0] src_width_reg;
    logic [rgbds_pkg::SIZE_W-1:0] src_height_reg;
    rgbds_pkg::tone_cfg_t         tone_cfg_reg;

    logic                 queue_full;
    logic                 queue_empty;
    logic                 push;
    logic                 pop;
    logic [COL_W-1:0]     sel_col;
    logic [ROW_W-1:0]     sel_row;
    logic                 sel_frame_end;
    logic [QUEUE_W-1:0]   push_data;
    logic [QUEUE_W-1:0]   pop_data;
    logic [BW-1:0]        q_red;
    logic [BW-1:0]        q_blue;
    logic [BW-1:0]        q_green;
    logic [COL_W-1:0]     q_col;
    logic [ROW_W-1:0]     q_row;
    logic                 q_frame_end;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg             <= rgbds_pkg::SRC_WIDTH_RST;
            src_height_reg            <= rgbds_pkg::SRC_HEIGHT_RST;
            tone_cfg_reg.red_gain     <= rgbds_pkg::RED_GAIN_RST;
            tone_cfg_reg.green_gain   <= rgbds_pkg::GREEN_GAIN_RST;
            tone_cfg_reg.blue_gain    <= rgbds_pkg::BLUE_GAIN_RST;
            tone_cfg_reg.red_offset   <= rgbds_pkg::RED_OFFSET_RST;
            tone_cfg_reg.green_offset <= rgbds_pkg::GREEN_OFFSET_RST;
            tone_cfg_reg.blue_offset  <= rgbds_pkg::BLUE_OFFSET_RST;
        end
        else if (cfg_write)
        begin
            case (rgbds_pkg::cfg_idx_t'(cfg_index))
                rgbds_pkg::CFG_SRC_WIDTH:    src_width_reg  <= cfg_data;
                rgbds_pkg::CFG_SRC_HEIGHT:   src_height_reg <= cfg_data;
                rgbds_pkg::CFG_RED_GAIN:     tone_cfg_reg.red_gain   <= cfg_data[BW-1:0];
                rgbds_pkg::CFG_GREEN_GAIN:   tone_cfg_reg.green_gain <= cfg_data[BW-1:0];
                rgbds_pkg::CFG_BLUE_GAIN:    tone_cfg_reg.blue_gain  <= cfg_data[BW-1:0];
                rgbds_pkg::CFG_RED_OFFSET:   tone_cfg_reg.red_offset <= cfg_data[BW-1:0];
                rgbds_pkg::CFG_GREEN_OFFSET: tone_cfg_reg.green_offset <= cfg_data[BW-1:0];
                rgbds_pkg::CFG_BLUE_OFFSET:  tone_cfg_reg.blue_offset  <= cfg_data[BW-1:0];
                default:                     src_width_reg  <= src_width_reg;
            endcase
        end
    end

    // Pixel selection
    rgbds_front #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_of_frame (start_of_frame),
        .src_width      (src_width_reg),
        .src_height     (src_height_reg),
        .queue_full     (queue_full),
        .push           (push),
        .col            (sel_col),
        .row            (sel_row),
        .frame_end      (sel_frame_end)
    );

    // Pack kept pixels for the queue
    assign push_data = {sel_frame_end, sel_row, sel_col, third_byte, second_byte, first_byte};

    rgbds_queue #(
        .WIDTH (QUEUE_W),
        .DEPTH (rgbds_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // Bytes arrive as red, blue, green
    assign {q_frame_end, q_row, q_col, q_green, q_blue, q_red} = pop_data;

    rgbds_back #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tone_cfg     (tone_cfg_reg),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .red_in       (q_red),
        .green_in     (q_green),
        .blue_in      (q_blue),
        .col_in       (q_col),
        .row_in       (q_row),
        .frame_end_in (q_frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel565     (pixel565),
        .out_col      (out_col),
        .out_row      (out_row),
        .frame_end    (frame_end)
    );

endmodule

`default_nettype wire

// ===== verif/tb_rgb888_downscale_gain_to_rgb565.sv =====
// Self-checking testbench for the RGB888 nearest-neighbour downscaler with colour correction.
`timescale 1ns / 100ps

module tb_rgb888_downscale_gain_to_rgb565;

    import rgbds_pkg::*;

    localparam int OUT_W        = 320;
    localparam int OUT_H        = 180;
    localparam int COL_W        = $clog2(OUT_W);
    localparam int ROW_W        = $clog2(OUT_H);
    localparam int DRAIN        = 10;
    localparam int END_WAIT     = 20000;
    localparam int LIMIT        = 200000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int MAX_REPORTS  = 30;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               last;
    } out_pixel_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_HALF,
        READY_PATTERN
    } stall_mode_t;

    // Tracks the sampling position and colour settings, and holds the pixels still owed
    class downscale_scoreboard;
        logic [SIZE_W-1:0]        width_reg;
        logic [SIZE_W-1:0]        height_reg;
        logic [GAIN_W-1:0]        gain_r, gain_g, gain_b;
        logic signed [BYTE_W-1:0] offs_r, offs_g, offs_b;
        int unsigned              col_count, row_count;
        int unsigned              col_next, row_next;
        int unsigned              col_target, row_target;
        int unsigned              col_rem, row_rem;
        out_pixel_t               awaited_pixels[$];
        int                       errors;

        function new();
            width_reg  = SRC_WIDTH_RST;
            height_reg = SRC_HEIGHT_RST;
            gain_r     = RED_GAIN_RST;
            gain_g     = GREEN_GAIN_RST;
            gain_b     = BLUE_GAIN_RST;
            offs_r     = RED_OFFSET_RST;
            offs_g     = GREEN_OFFSET_RST;
            offs_b     = BLUE_OFFSET_RST;
            errors     = 0;
            clear_frame();
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SRC_WIDTH:    width_reg  = data;
                CFG_SRC_HEIGHT:   height_reg = data;
                CFG_RED_GAIN:     gain_r     = data[7:0];
                CFG_GREEN_GAIN:   gain_g     = data[7:0];
                CFG_BLUE_GAIN:    gain_b     = data[7:0];
                CFG_RED_OFFSET:   offs_r     = data[7:0];
                CFG_GREEN_OFFSET: offs_g     = data[7:0];
                CFG_BLUE_OFFSET:  offs_b     = data[7:0];
                default: ;
            endcase
        endfunction

        function void clear_columns();
            col_count  = 0;
            col_next   = 0;
            col_target = 0;
            col_rem    = 0;
        endfunction

        function void clear_frame();
            clear_columns();
            row_count  = 0;
            row_next   = 0;
            row_target = 0;
            row_rem    = 0;
        endfunction

        // Zero reads as one, anything past the largest size as the largest size
        function int unsigned fit_size(logic [SIZE_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_SIZE)
                return MAX_SIZE;
            return int'(v);
        endfunction

        // Scale by gain in hundredths, add the offset, clamp to a byte
        function logic [7:0] grade(logic [7:0] v, logic [7:0] gain, logic signed [7:0] offs);
            int x;
            x = (int'(v) * int'(gain)) / 100 + int'(offs);
            if (x > 255)
                x = 255;
            if (x < 0)
                x = 0;
            return x[7:0];
        endfunction

        function void take_source_pixel(bit sof, logic [7:0] red, logic [7:0] blue,
                                        logic [7:0] green);
            int unsigned w, h;
            bit          live;
            logic [7:0]  r, g, b;
            out_pixel_t  px;
            w = fit_size(width_reg);
            h = fit_size(height_reg);
            if (sof)
                clear_frame();
            live = (row_next < OUT_H) && (row_count == row_target);

            // Keep this pixel if it sits on the chosen row and column
            if (live && col_next < OUT_W && col_count == col_target)
            begin
                r = grade(red, gain_r, offs_r);
                g = grade(green, gain_g, offs_g);
                b = grade(blue, gain_b, offs_b);
                px.pixel = {r[7:3], g[7:2], b[7:3]};
                px.col   = COL_W'(col_next);
                px.row   = ROW_W'(row_next);
                px.last  = (col_next == OUT_W - 1) && (row_next == OUT_H - 1);
                awaited_pixels.push_back(px);
                col_next++;
                col_target += w / OUT_W;
                col_rem    += w % OUT_W;
                if (col_rem >= OUT_W)
                begin
                    col_rem -= OUT_W;
                    col_target++;
                end
            end

            // Advance the source position; wrap at line end and at frame end
            if (col_count + 1 >= w)
            begin
                if (row_count + 1 >= h)
                begin
                    clear_frame();
                end
                else
                begin
                    clear_columns();
                    if (live)
                    begin
                        row_next++;
                        row_target += h / OUT_H;
                        row_rem    += h % OUT_H;
                        if (row_rem >= OUT_H)
                        begin
                            row_rem -= OUT_H;
                            row_target++;
                        end
                    end
                    row_count++;
                end
            end
            else
            begin
                col_count++;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        task check_output_pixel(out_pixel_t got);
            out_pixel_t want;
            if (awaited_pixels.size() == 0)
            begin
                report($sformatf("unexpected pixel %h at col %0d row %0d",
                                 got.pixel, got.col, got.row));
                return;
            end
            want = awaited_pixels.pop_front();
            if (got.pixel !== want.pixel)
                report($sformatf("pixel565 %h, want %h (col %0d row %0d)",
                                 got.pixel, want.pixel, want.col, want.row));
            if (got.col !== want.col)
                report($sformatf("out_col %0d, want %0d", got.col, want.col));
            if (got.row !== want.row)
                report($sformatf("out_row %0d, want %0d", got.row, want.row));
            if (got.last !== want.last)
                report($sformatf("frame_end %b, want %b (col %0d row %0d)",
                                 got.last, want.last, want.col, want.row));
        endtask
    endclass

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   cfg_write      = 1'b0;
    cfg_idx_t               cfg_index      = CFG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                   in_valid       = 1'b0;
    logic                   start_of_frame = 1'b0;
    logic [BYTE_W-1:0]      first_byte     = '0;
    logic [BYTE_W-1:0]      second_byte    = '0;
    logic [BYTE_W-1:0]      third_byte     = '0;
    logic                   out_ready      = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [PIXEL_W-1:0]     pixel565;
    logic [COL_W-1:0]       out_col;
    logic [ROW_W-1:0]       out_row;
    logic                   frame_end;

    downscale_scoreboard sb = new();
    int                  burst_left = 0;
    int                  cycles = 0;

    rgb888_downscale_gain_to_rgb565 #(
        .OUT_WIDTH  (OUT_W),
        .OUT_HEIGHT (OUT_H)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_of_frame (start_of_frame),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .third_byte     (third_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel565       (pixel565),
        .out_col        (out_col),
        .out_row        (out_row),
        .frame_end      (frame_end)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check every output transfer against the oldest owed pixel
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_output_pixel(out_pixel_t'({pixel565, out_col, out_row, frame_end}));
    end

    // Stall the output side in spans of differing character
    initial
    begin
        stall_mode_t mode;
        int          span;
        int          low;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 300);
            low  = $urandom_range(1, 8);
            for (int n = 0; n < span; n++)
            begin
                @(posedge clk);
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                    READY_HALF:   out_ready <= ($urandom_range(0, 1) != 0);
                    default:      out_ready <= (n % (low + 4)) >= low;
                endcase
            end
        end
    end

    // Offer one source pixel in bursts with gaps, hold until the transfer
    task send_pixel(input bit sof, input logic [7:0] red, input logic [7:0] blue,
                    input logic [7:0] green);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid       <= 1'b1;
        start_of_frame <= sof;
        first_byte     <= red;
        second_byte    <= blue;
        third_byte     <= green;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_source_pixel(sof, red, blue, green);
    endtask

    task send_noise(input bit sof);
        send_pixel(sof, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Drop valid, let every owed pixel out and the pipeline empty
    task settle();
        in_valid <= 1'b0;
        while (sb.awaited_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // Write all registers; byte registers carry junk in their upper bits
    task configure(input int w, input int h, input int rg, input int gg, input int bg,
                   input int ro, input int go, input int bo);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[CFG_SRC_WIDTH]    = CFG_DATA_W'(w);
        vals[CFG_SRC_HEIGHT]   = CFG_DATA_W'(h);
        vals[CFG_RED_GAIN]     = {5'($urandom), 8'(rg)};
        vals[CFG_GREEN_GAIN]   = {5'($urandom), 8'(gg)};
        vals[CFG_BLUE_GAIN]    = {5'($urandom), 8'(bg)};
        vals[CFG_RED_OFFSET]   = {5'($urandom), 8'(ro)};
        vals[CFG_GREEN_OFFSET] = {5'($urandom), 8'(go)};
        vals[CFG_BLUE_OFFSET]  = {5'($urandom), 8'(bo)};
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_register(cfg_idx_t'(i), vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    function int pick_gain();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function int pick_offset();
        case ($urandom_range(0, 5))
            0:       return -128;
            1:       return 127;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // One setting, then a run of random pixels mostly forming well-formed frames
    task run_random_phase(input int items);
        int w, h;
        case ($urandom_range(0, 3))
            0:
            begin
                // Very short lines, tall frame: exercises row stepping
                w = $urandom_range(0, 3);
                h = $urandom_range(180, 420);
            end
            1:
            begin
                w = $urandom_range(320, 1400);
                h = $urandom_range(0, 400);
            end
            2:
            begin
                w = ($urandom_range(0, 1) == 0) ? MAX_SIZE : $urandom_range(4097, 8191);
                h = $urandom_range(0, 8191);
            end
            default:
            begin
                w = $urandom_range(0, 24);
                h = $urandom_range(0, 24);
            end
        endcase
        configure(w, h, pick_gain(), pick_gain(), pick_gain(),
                  pick_offset(), pick_offset(), pick_offset());
        for (int n = 0; n < items; n++)
            send_noise((n == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 299) == 0);
        settle();
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: 1280 wide, keep every fourth column
        send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
        send_pixel(1'b0, 8'h80, 8'h7F, 8'h01);
        send_pixel(1'b0, 8'h07, 8'hC8, 8'h40);
        send_pixel(1'b0, 8'h21, 8'h42, 8'h63);
        settle();

        // Zero sizes read as one: every pixel is a whole frame; clamp at both ends
        configure(0, 0, 255, 255, 255, -128, 127, 0);
        send_pixel(1'b0, 8'hFF, 8'h00, 8'h80);
        send_pixel(1'b0, 8'h00, 8'hFF, 8'hFF);
        send_pixel(1'b1, 8'h7F, 8'h80, 8'h00);
        send_pixel(1'b0, 8'h01, 8'h02, 8'h03);
        settle();

        // Tiny upscaling frame: line ends and frame overrun without a start flag
        configure(2, 3, 0, 100, 255, 127, -1, -128);
        send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
        repeat (6) send_noise(1'b0);
        settle();

        // Oversized width and height, restarted by start of frame mid-line
        configure(8191, 5000, 200, 50, 150, -20, 30, 5);
        send_noise(1'b1);
        send_noise(1'b0);
        send_noise(1'b0);
        send_noise(1'b1);
        send_noise(1'b0);
        settle();

        // One full line at output width: reaches the last output column
        configure(OUT_W, OUT_H, pick_gain(), pick_gain(), pick_gain(),
                  pick_offset(), pick_offset(), pick_offset());
        for (int n = 0; n < OUT_W; n++)
            send_noise(n == 0);
        settle();

        // Random settings and content
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = $urandom_range(120, 360);
            run_random_phase(len);
            sent += len;
        end

        // Wait out the last pixels, then give stray outputs a chance to show
        in_valid <= 1'b0;
        for (int n = 0; n < END_WAIT && sb.awaited_pixels.size() != 0; n++)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.awaited_pixels.size() != 0)
            sb.report($sformatf("%0d pixels never arrived", sb.awaited_pixels.size()));

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rgbds_pkg.sv
rtl/rgbds_queue.sv
rtl/rgbds_front.sv
rtl/rgbds_back.sv
rtl/rgb888_downscale_gain_to_rgb565.sv
verif/tb_rgb888_downscale_gain_to_rgb565.sv
